[src/btmq_pkg.sv]
// Shared types and constants for the bus target message queue.
package btmq_pkg;

    // Sizing of the message ring.
    localparam int QUEUE_DEPTH   = 32;
    localparam int MESSAGE_BYTES = 32;
    localparam int PACKET_BYTES  = 32;

    localparam int DATA_CAP = MESSAGE_BYTES - 2;
    // Running index must also hold the version read position (up to 3).
    localparam int IDX_CAP  = (DATA_CAP > 4) ? DATA_CAP : 4;
    localparam int IDX_W    = $clog2(IDX_CAP);
    localparam int LEN_W    = IDX_W;
    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_AW  = SLOT_W + IDX_W;

    // Command queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 2);

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_THIRD  = 2'd2;

    // Target register codes.
    localparam logic [7:0] REG_VERSION = 8'h42;
    localparam logic [7:0] REG_AVAIL   = 8'hE0;
    localparam logic [7:0] REG_EXT     = 8'hE1;
    localparam logic [7:0] BYTE_NONE   = 8'hFF;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_POP   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] bus_byte;
        logic       ext_available;
        logic [7:0] ext_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       pop_empty;
        logic       last;
        logic       has_messages;
    } t_out_item;

    // One queued command: a finished single result or a message pop.
    typedef struct packed {
        logic                is_pop;
        logic [SLOT_W-1:0]   slot;
        t_out_item           res;
    } t_cmd;

    // Ring storage write request from the front.
    typedef struct packed {
        logic               reg_we;
        logic               len_we;
        logic               data_we;
        logic [SLOT_W-1:0]  slot;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         wbyte;
        logic [LEN_W-1:0]   len;
    } t_store_wr;

    // Ring storage read data toward the back.
    typedef struct packed {
        logic [7:0]       reg_q;
        logic [LEN_W-1:0] len_q;
        logic [7:0]       data_q;
    } t_store_rd;

endpackage

[src/bus_target_message_queue.sv]
// Top level of the bus target message queue.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  input    | i_in_valid  / o_in_ready   | i_in  (kind, bytes, ext flag)
//  result   | o_res_valid / i_res_ready  | o_res (byte, flags, last)
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Each request is captured, then executed against the registered read of the write
//  slot; the input takes no new request until the held one has been executed.
//  A pop gives 2 + length results: register and length, then each data byte through
//  a registered data memory read and then the result register.
//  Input stalls when the two-entry command queue is full, or when the ring writer
//  would reach a slot whose pop is still being read out.
//  Reset is synchronous; ring memories are not cleared and need no sweep.
module bus_target_message_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  btmq_pkg::t_in_item             i_in,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output btmq_pkg::t_out_item            o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [btmq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    btmq_pkg::t_store_wr           wr;
    btmq_pkg::t_store_rd           rd;
    logic [btmq_pkg::SLOT_W-1:0]   front_slot;
    logic [7:0]                    front_reg_q;
    logic [btmq_pkg::SLOT_W-1:0]   hdr_slot;
    logic [btmq_pkg::DATA_AW-1:0]  data_addr;
    logic                          push;
    btmq_pkg::t_cmd                cmd;
    logic                          fifo_full;
    logic                          cmd_take;
    logic                          fifo_valid;
    btmq_pkg::t_cmd                head;
    logic                          pop_done;

    btmq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_wr         (wr),
        .o_rd_slot    (front_slot),
        .i_reg_q      (front_reg_q),
        .o_push       (push),
        .o_cmd        (cmd),
        .i_fifo_full  (fifo_full),
        .i_pop_done   (pop_done)
    );

    btmq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (fifo_full),
        .i_pop   (cmd_take),
        .o_valid (fifo_valid),
        .o_head  (head)
    );

    btmq_store u_store (
        .i_clk         (i_clk),
        .i_wr          (wr),
        .i_front_slot  (front_slot),
        .o_front_reg_q (front_reg_q),
        .i_hdr_slot    (hdr_slot),
        .i_data_addr   (data_addr),
        .o_rd          (rd)
    );

    btmq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (fifo_valid),
        .i_head       (head),
        .o_cmd_take   (cmd_take),
        .o_hdr_slot   (hdr_slot),
        .o_data_addr  (data_addr),
        .i_rd         (rd),
        .o_pop_done   (pop_done),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_res        (o_res)
    );

endmodule

[src/btmq_store.sv]
// Message ring storage: register, length and data memories.
module btmq_store (
    input  logic                        i_clk,
    input  btmq_pkg::t_store_wr         i_wr,
    input  logic [btmq_pkg::SLOT_W-1:0] i_front_slot,
    output logic [7:0]                  o_front_reg_q,
    input  logic [btmq_pkg::SLOT_W-1:0] i_hdr_slot,
    input  logic [btmq_pkg::DATA_AW-1:0] i_data_addr,
    output btmq_pkg::t_store_rd         o_rd
);

    logic [7:0]                 mem_reg  [btmq_pkg::QUEUE_DEPTH];
    logic [btmq_pkg::LEN_W-1:0] mem_len  [btmq_pkg::QUEUE_DEPTH];
    logic [7:0]                 mem_data [btmq_pkg::QUEUE_DEPTH * (2 ** btmq_pkg::IDX_W)];

    logic [7:0]                 r_front_reg_q;
    logic [7:0]                 r_hdr_reg_q;
    logic [btmq_pkg::LEN_W-1:0] r_hdr_len_q;
    logic [7:0]                 r_data_q;

    // Writes from the front
    always_ff @(posedge i_clk) begin
        if (i_wr.reg_we) begin
            mem_reg[i_wr.slot] <= i_wr.wbyte;
        end
        if (i_wr.len_we) begin
            mem_len[i_wr.slot] <= i_wr.len;
        end
        if (i_wr.data_we) begin
            mem_data[{i_wr.slot, i_wr.idx}] <= i_wr.wbyte;
        end
    end

    // Registered reads: front register port, back header and data ports
    always_ff @(posedge i_clk) begin
        r_front_reg_q <= mem_reg[i_front_slot];
        r_hdr_reg_q   <= mem_reg[i_hdr_slot];
        r_hdr_len_q   <= mem_len[i_hdr_slot];
        r_data_q      <= mem_data[i_data_addr];
    end

    assign o_front_reg_q = r_front_reg_q;
    assign o_rd.reg_q    = r_hdr_reg_q;
    assign o_rd.len_q    = r_hdr_len_q;
    assign o_rd.data_q   = r_data_q;

endmodule

[src/btmq_fifo.sv]
// Short command queue between the front and the back.
module btmq_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  btmq_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output btmq_pkg::t_cmd  o_head
);

    btmq_pkg::t_cmd                r_ent [btmq_pkg::FIFO_DEPTH];
    logic [btmq_pkg::FIFO_PW-1:0]  r_wptr;
    logic [btmq_pkg::FIFO_PW-1:0]  r_rptr;
    logic [btmq_pkg::FIFO_CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == btmq_pkg::FIFO_CW'(btmq_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_ent[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == btmq_pkg::FIFO_PW'(btmq_pkg::FIFO_DEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == btmq_pkg::FIFO_PW'(btmq_pkg::FIFO_DEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Front never pushes into a full queue, back never pops an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue underflow");

endmodule

[src/btmq_front.sv]
// Front: takes bus events and pops, runs the target state, queues commands.
module btmq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  btmq_pkg::t_in_item            i_in,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [btmq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    output btmq_pkg::t_store_wr           o_wr,
    output logic [btmq_pkg::SLOT_W-1:0]   o_rd_slot,
    input  logic [7:0]                    i_reg_q,
    output logic                          o_push,
    output btmq_pkg::t_cmd                o_cmd,
    input  logic                          i_fifo_full,
    input  logic                          i_pop_done
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_RECV = 4'b0010,
        PH_REQ  = 4'b0100,
        PH_HOLD = 4'b1000
    } t_phase;

    t_phase                        r_phase,  n_phase;
    logic [btmq_pkg::IDX_W-1:0]    r_idx,    n_idx;
    logic [btmq_pkg::SLOT_W-1:0]   r_wslot,  n_wslot;
    logic [btmq_pkg::SLOT_W-1:0]   r_rslot,  n_rslot;
    logic [btmq_pkg::CNT_W-1:0]    r_count,  n_count;
    logic [btmq_pkg::PEND_W-1:0]   r_pend,   n_pend;
    logic                          r_busy;
    btmq_pkg::t_in_item            r_item;
    logic [7:0]                    r_ver [3];

    logic                          accept;
    logic                          full;
    logic                          hazard;
    logic [btmq_pkg::IDX_W:0]      idx_inc;
    logic [btmq_pkg::IDX_W-1:0]    idx_step;
    logic [btmq_pkg::CNT_W:0]      held;
    logic                          pop_issue;
    logic [7:0]                    rd_val;

    // Pops still being read by the back hold their slots; stop writers
    // from reaching them.
    assign held   = {1'b0, r_count} + (btmq_pkg::CNT_W + 1)'(r_pend);
    assign hazard = (r_pend != '0) &&
                    (held >= (btmq_pkg::CNT_W + 1)'(btmq_pkg::QUEUE_DEPTH));

    assign o_in_ready  = !r_busy && !i_fifo_full && !hazard;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_rd_slot   = r_wslot;

    assign full     = (r_count == btmq_pkg::CNT_W'(btmq_pkg::QUEUE_DEPTH));
    assign idx_inc  = {1'b0, r_idx} + 1'b1;
    assign idx_step = (idx_inc >= (btmq_pkg::IDX_W + 1)'(btmq_pkg::DATA_CAP)) ?
                      btmq_pkg::IDX_W'(1) : idx_inc[btmq_pkg::IDX_W-1:0];

    // Bus read answer from the register held at the write slot
    always_comb begin
        rd_val = btmq_pkg::BYTE_NONE;
        case (i_reg_q)
            btmq_pkg::REG_VERSION: begin
                if (r_idx < btmq_pkg::IDX_W'(3)) begin
                    case (r_idx[1:0])
                        2'd0:    rd_val = r_ver[0];
                        2'd1:    rd_val = r_ver[1];
                        default: rd_val = r_ver[2];
                    endcase
                end
            end
            btmq_pkg::REG_AVAIL: rd_val = {7'd0, r_item.ext_available};
            btmq_pkg::REG_EXT: begin
                if (32'(r_idx) < btmq_pkg::PACKET_BYTES) begin
                    rd_val = r_item.ext_byte;
                end
            end
            default: rd_val = btmq_pkg::BYTE_NONE;
        endcase
    end

    // Execute the held item
    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_wslot   = r_wslot;
        n_rslot   = r_rslot;
        n_count   = r_count;
        o_wr      = '0;
        o_wr.slot = r_wslot;
        o_wr.idx  = r_idx;
        o_wr.wbyte = r_item.bus_byte;
        o_wr.len  = r_idx;
        o_push    = 1'b0;
        o_cmd     = '0;
        pop_issue = 1'b0;
        if (r_busy) begin
            o_push = 1'b1;
            o_cmd.res.last = 1'b1;
            case (r_item.kind)
                btmq_pkg::KIND_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        o_wr.reg_we = !full;
                        n_phase     = PH_RECV;
                    end else begin
                        o_wr.data_we = !full &&
                            ({1'b0, r_idx} < (btmq_pkg::IDX_W + 1)'(btmq_pkg::DATA_CAP));
                        n_idx = idx_step;
                    end
                end
                btmq_pkg::KIND_READ: begin
                    n_phase = PH_REQ;
                    o_cmd.res.out_byte  = rd_val;
                    o_cmd.res.out_valid = 1'b1;
                    if ((i_reg_q == btmq_pkg::REG_VERSION) &&
                        (r_idx < btmq_pkg::IDX_W'(3))) begin
                        n_idx = idx_inc[btmq_pkg::IDX_W-1:0];
                    end
                end
                btmq_pkg::KIND_STOP: begin
                    case (r_phase)
                        PH_REQ: begin
                            n_phase = PH_IDLE;
                            n_idx   = '0;
                        end
                        PH_RECV: begin
                            if (r_idx == '0) begin
                                n_phase = PH_HOLD;
                            end else begin
                                // commit, or drop into a full ring
                                if (!full) begin
                                    o_wr.len_we = 1'b1;
                                    n_count = r_count + 1'b1;
                                    n_wslot = (r_wslot ==
                                        btmq_pkg::SLOT_W'(btmq_pkg::QUEUE_DEPTH - 1)) ?
                                        '0 : r_wslot + 1'b1;
                                end
                                n_phase = PH_IDLE;
                                n_idx   = '0;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
                btmq_pkg::KIND_POP: begin
                    if (r_count == '0) begin
                        o_cmd.res.pop_empty = 1'b1;
                    end else begin
                        pop_issue    = 1'b1;
                        o_cmd.is_pop = 1'b1;
                        o_cmd.slot   = r_rslot;
                        n_count      = r_count - 1'b1;
                        n_rslot      = (r_rslot ==
                            btmq_pkg::SLOT_W'(btmq_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rslot + 1'b1;
                    end
                end
                default: o_push = 1'b1;
            endcase
            o_cmd.res.has_messages = (n_count != '0);
        end
    end

    // Outstanding pops in the queue or the back
    always_comb begin
        case ({pop_issue, i_pop_done})
            2'b10:   n_pend = r_pend + 1'b1;
            2'b01:   n_pend = r_pend - 1'b1;
            default: n_pend = r_pend;
        endcase
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_idx    <= '0;
            r_wslot  <= '0;
            r_rslot  <= '0;
            r_count  <= '0;
            r_pend   <= '0;
            r_busy   <= 1'b0;
            r_ver[0] <= 8'd1;
            r_ver[1] <= 8'd2;
            r_ver[2] <= 8'd3;
        end else begin
            r_busy  <= accept;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_wslot <= n_wslot;
            r_rslot <= n_rslot;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    btmq_pkg::CFG_VERSION_FIRST:  r_ver[0] <= i_cfg_data;
                    btmq_pkg::CFG_VERSION_SECOND: r_ver[1] <= i_cfg_data;
                    btmq_pkg::CFG_VERSION_THIRD:  r_ver[2] <= i_cfg_data;
                    default: r_ver[0] <= r_ver[0];
                endcase
            end
        end
    end

    // Every accepted request yields one queued command next cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_push)
        else $error("accepted request produced no command");
    // Queued plus in-flight messages never exceed the ring
    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held <= (btmq_pkg::CNT_W + 1)'(btmq_pkg::QUEUE_DEPTH))
        else $error("ring overcommitted");

endmodule

[src/btmq_back.sv]
// Back: drains commands, reads popped messages, drives the result register.
module btmq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fifo_valid,
    input  btmq_pkg::t_cmd                i_head,
    output logic                          o_cmd_take,
    output logic [btmq_pkg::SLOT_W-1:0]   o_hdr_slot,
    output logic [btmq_pkg::DATA_AW-1:0]  o_data_addr,
    input  btmq_pkg::t_store_rd           i_rd,
    output logic                          o_pop_done,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output btmq_pkg::t_out_item           o_res
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_HDR  = 5'b00010,
        B_LEN  = 5'b00100,
        B_DRD  = 5'b01000,
        B_DOUT = 5'b10000
    } t_bstate;

    t_bstate                       r_state, n_state;
    logic [btmq_pkg::SLOT_W-1:0]   r_slot,  n_slot;
    logic                          r_has,   n_has;
    logic [btmq_pkg::LEN_W-1:0]    r_len,   n_len;
    logic [btmq_pkg::IDX_W-1:0]    r_idx,   n_idx;
    logic                          r_ov;
    btmq_pkg::t_out_item           r_out;

    logic                          out_free;
    logic                          load;
    btmq_pkg::t_out_item           ld;
    logic                          last_byte;

    assign out_free    = !r_ov || i_res_ready;
    assign o_hdr_slot  = (r_state == B_IDLE) ? i_head.slot : r_slot;
    assign o_data_addr = {r_slot, r_idx};
    assign last_byte   = (({1'b0, r_idx} + 1'b1) == {1'b0, r_len});
    assign o_res_valid = r_ov;
    assign o_res       = r_out;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_has      = r_has;
        n_len      = r_len;
        n_idx      = r_idx;
        load       = 1'b0;
        ld         = '0;
        o_cmd_take = 1'b0;
        o_pop_done = 1'b0;
        ld.has_messages = r_has;
        ld.out_valid    = 1'b1;
        case (r_state)
            B_IDLE: begin
                if (i_fifo_valid && out_free) begin
                    o_cmd_take = 1'b1;
                    if (!i_head.is_pop) begin
                        load = 1'b1;
                        ld   = i_head.res;
                    end else begin
                        n_slot  = i_head.slot;
                        n_has   = i_head.res.has_messages;
                        n_state = B_HDR;
                    end
                end
            end
            B_HDR: begin
                if (out_free) begin
                    load        = 1'b1;
                    ld.out_byte = i_rd.reg_q;
                    n_len       = i_rd.len_q;
                    n_state     = B_LEN;
                end
            end
            B_LEN: begin
                if (out_free) begin
                    load        = 1'b1;
                    ld.out_byte = 8'(r_len);
                    ld.last     = (r_len == '0);
                    if (r_len == '0) begin
                        o_pop_done = 1'b1;
                        n_state    = B_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_state = B_DRD;
                    end
                end
            end
            B_DRD: n_state = B_DOUT;
            B_DOUT: begin
                if (out_free) begin
                    load        = 1'b1;
                    ld.out_byte = i_rd.data_q;
                    ld.last     = last_byte;
                    if (last_byte) begin
                        o_pop_done = 1'b1;
                        n_state    = B_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = B_DRD;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= ld;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
            r_slot  <= '0;
            r_has   <= 1'b0;
            r_len   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_has   <= n_has;
            r_len   <= n_len;
            r_idx   <= n_idx;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // A pop completes only while handing its final byte to the result register
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop_done |=> (r_ov && r_out.last && r_out.out_valid))
        else $error("pop finished without a final result");

endmodule
